// ----- hw/rtl/smh_pkg.sv -----
`timescale 1ns / 1ps

package smh_pkg;

    localparam int unsigned BLOCK_BITS   = 512;
    localparam int unsigned OUT_TDATA_W  = 40;
    localparam logic [5:0]  LEN_OFFSET   = 6'd56;
    localparam logic [5:0]  LAST_BYTE    = 6'd63;
    localparam logic [5:0]  LAST_ROUND   = 6'd63;
    localparam logic [2:0]  LAST_WORD    = 3'd7;
    localparam logic [7:0]  PAD_MARK     = 8'h80;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_FOLD  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    typedef logic [31:0] t_word;

    localparam t_word INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ----- hw/rtl/sha256_message_hasher.sv -----
`timescale 1ns / 1ps

// channel    dir  tdata                          tuser          tlast
// s_axis     in   [7:0] msg_byte                 byte_present   end_of_message
// m_axis     out  [31:0] digest_word,            -              last_word
//                 [34:32] word_index, rest zero
//
// a message byte is taken whenever s_axis is ready; a byte that fills the
// 64-byte block starts the rounds and a fold on the single shared round unit
// end of message: the padding bytes (up to 72 with an extra length block) go
// in one by one, each padded block is compressed, then eight output transfers
// synchronous active-low reset returns to the initial hash values, empty buffer
// s_axis is not ready while padding, compressing or sending the digest;
// a stalled m_axis holds the current digest word

module sha256_message_hasher
    import smh_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [7:0]             i_s_axis_tdata,   // [7:0] msg_byte
    input  logic                   i_s_axis_tuser,   // [0] byte_present
    input  logic                   i_s_axis_tlast,   // end_of_message
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic                   o_m_axis_tlast    // last_word
);

    // control state
    t_state                r_state, n_state;
    logic [5:0]            r_fill, n_fill;
    logic [63:0]           r_bit_count, n_bit_count;
    t_word                 r_chain [8];
    t_word                 n_chain [8];
    logic [5:0]            r_round, n_round;
    logic                  r_pad_first, n_pad_first;   // next pad byte is the 0x80 mark
    logic                  r_len_ok, n_len_ok;         // this block may carry the length
    logic                  r_in_pad, n_in_pad;
    logic                  r_end_pend, n_end_pend;     // end seen on a block-filling byte
    logic                  r_final, n_final;           // block in flight is the last one
    logic [2:0]            r_out_idx, n_out_idx;

    // datapath: byte shift line that doubles as the rolling schedule window
    logic [BLOCK_BITS-1:0] r_blk, n_blk;
    t_word                 r_v [8];
    t_word                 n_v [8];

    logic                  s_in_fire;
    logic                  s_out_fire;
    logic [7:0]            s_pad_byte;
    logic [7:0]            s_len_byte;
    t_word                 s_w0, s_w1, s_w9, s_w14, s_w_new;
    t_word                 s_t1, s_t2, s_ch, s_maj;

    assign s_in_fire  = i_s_axis_tvalid & o_s_axis_tready;
    assign s_out_fire = o_m_axis_tvalid & i_m_axis_tready;

    // schedule taps, word j sits at bits [511-32j -: 32]
    assign s_w0  = r_blk[511:480];
    assign s_w1  = r_blk[479:448];
    assign s_w9  = r_blk[223:192];
    assign s_w14 = r_blk[63:32];
    assign s_w_new = small_sigma1(s_w14) + s_w9 + small_sigma0(s_w1) + s_w0;

    // round unit
    assign s_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign s_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign s_t1  = r_v[7] + big_sigma1(r_v[4]) + s_ch + ROUND_K[r_round] + s_w0;
    assign s_t2  = big_sigma0(r_v[0]) + s_maj;

    // length bytes go out big-endian at byte positions 56..63
    assign s_len_byte = r_bit_count[{~r_fill[2:0], 3'b000} +: 8];

    always_comb begin
        if (r_pad_first) begin
            s_pad_byte = PAD_MARK;
        end else if (r_len_ok && (r_fill >= LEN_OFFSET)) begin
            s_pad_byte = s_len_byte;
        end else begin
            s_pad_byte = 8'h00;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_bit_count = r_bit_count;
        n_chain     = r_chain;
        n_round     = r_round;
        n_pad_first = r_pad_first;
        n_len_ok    = r_len_ok;
        n_in_pad    = r_in_pad;
        n_end_pend  = r_end_pend;
        n_final     = r_final;
        n_out_idx   = r_out_idx;
        n_blk       = r_blk;
        n_v         = r_v;

        unique case (r_state)
            S_IDLE: begin
                if (s_in_fire) begin
                    if (i_s_axis_tuser) begin
                        n_blk       = {r_blk[BLOCK_BITS-9:0], i_s_axis_tdata};
                        n_fill      = r_fill + 6'd1;
                        n_bit_count = r_bit_count + 64'd8;
                    end
                    if (i_s_axis_tuser && (r_fill == LAST_BYTE)) begin
                        // block full: compress first, pad afterwards if end came along
                        n_state    = S_ROUND;
                        n_v        = r_chain;
                        n_end_pend = i_s_axis_tlast;
                        n_final    = 1'b0;
                    end else if (i_s_axis_tlast) begin
                        n_state     = S_PAD;
                        n_pad_first = 1'b1;
                        n_in_pad    = 1'b1;
                    end
                end
            end
            S_PAD: begin
                n_blk       = {r_blk[BLOCK_BITS-9:0], s_pad_byte};
                n_fill      = r_fill + 6'd1;
                n_pad_first = 1'b0;
                if (r_pad_first) begin
                    // mark past byte 55 forces an extra length block
                    n_len_ok = (r_fill < LEN_OFFSET);
                end
                if (r_fill == LAST_BYTE) begin
                    n_state = S_ROUND;
                    n_v     = r_chain;
                    n_final = !r_pad_first && r_len_ok;
                end
            end
            S_ROUND: begin
                n_v[7]  = r_v[6];
                n_v[6]  = r_v[5];
                n_v[5]  = r_v[4];
                n_v[4]  = r_v[3] + s_t1;
                n_v[3]  = r_v[2];
                n_v[2]  = r_v[1];
                n_v[1]  = r_v[0];
                n_v[0]  = s_t1 + s_t2;
                n_blk   = {r_blk[BLOCK_BITS-33:0], s_w_new};
                n_round = r_round + 6'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                for (int i = 0; i < 8; i++) begin
                    n_chain[i] = r_chain[i] + r_v[i];
                end
                priority if (r_final) begin
                    n_state   = S_OUT;
                    n_final   = 1'b0;
                    n_out_idx = '0;
                end else if (r_end_pend) begin
                    n_state     = S_PAD;
                    n_end_pend  = 1'b0;
                    n_pad_first = 1'b1;
                    n_in_pad    = 1'b1;
                end else if (r_in_pad) begin
                    // second padding block: zeros then the length
                    n_state  = S_PAD;
                    n_len_ok = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (s_out_fire) begin
                    if (r_out_idx == LAST_WORD) begin
                        n_state     = S_IDLE;
                        n_chain     = INIT_HASH;
                        n_fill      = '0;
                        n_bit_count = '0;
                        n_in_pad    = 1'b0;
                        n_len_ok    = 1'b0;
                        n_out_idx   = '0;
                    end else begin
                        n_out_idx = r_out_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_bit_count <= '0;
            r_chain     <= INIT_HASH;
            r_round     <= '0;
            r_pad_first <= 1'b0;
            r_len_ok    <= 1'b0;
            r_in_pad    <= 1'b0;
            r_end_pend  <= 1'b0;
            r_final     <= 1'b0;
            r_out_idx   <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_bit_count <= n_bit_count;
            r_chain     <= n_chain;
            r_round     <= n_round;
            r_pad_first <= n_pad_first;
            r_len_ok    <= n_len_ok;
            r_in_pad    <= n_in_pad;
            r_end_pend  <= n_end_pend;
            r_final     <= n_final;
            r_out_idx   <= n_out_idx;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_v   <= n_v;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = {5'b00000, r_out_idx, r_chain[r_out_idx]};
    assign o_m_axis_tlast  = (r_out_idx == LAST_WORD);

`ifndef ASSERT_OFF
    // never take input while a digest is pending
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input accepted during digest output");

    // round counter only moves inside a compression
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ROUND) |-> (r_round == 6'd0))
        else $error("round counter not parked outside compression");

    // fold only follows the last round
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD) |-> ($past(r_state) == S_ROUND && $past(r_round) == LAST_ROUND))
        else $error("fold without full set of rounds");

    // after the final digest word the message state is fresh
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_out_fire && o_m_axis_tlast) |=>
            (o_s_axis_tready && r_fill == 6'd0 && r_bit_count == 64'd0 && !r_in_pad))
        else $error("message state not cleared after digest");
`endif

endmodule
